[hw/rtl/priority_voice_allocator_unit_macros.svh]
// ----------------------------------------------------------------------------
// Priority voice allocator - assertion macros
// Shared concurrent assertion forms used by the allocator checker.
// ----------------------------------------------------------------------------
`ifndef PRIORITY_VOICE_ALLOCATOR_UNIT_MACROS_SVH
`define PRIORITY_VOICE_ALLOCATOR_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is high
`define PVA_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("allocator check failed");

// Next-cycle implication, disabled while reset is high
`define PVA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("allocator check failed");

`endif

[hw/rtl/pva_pkg.sv]
// ----------------------------------------------------------------------------
// Priority voice allocator - package
// Field widths, command codes and shared types of the allocator.
// ----------------------------------------------------------------------------
package pva_pkg;

   localparam int PRI_W   = 8;
   localparam int TRACK_W = 4;

   // Command codes of the input word
   localparam logic CMD_REQUEST = 1'b0;
   localparam logic CMD_RELEASE = 1'b1;

   // Sequencer states, one-hot
   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SCAN   = 3'b010,
      ST_COMMIT = 3'b100
   } state_type;

   // Outcome flags of a scan, handed from the selector to the sequencer
   typedef struct packed {
      logic idle_found;
      logic steal_found;
   } pick_type;

endpackage

[hw/rtl/pva_mem.sv]
// ----------------------------------------------------------------------------
// Priority voice allocator - track memory
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module pva_mem #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 40
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write the entry
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Register the read word
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/pva_select.sv]
// ----------------------------------------------------------------------------
// Priority voice allocator - scan selector
// Folds one track word per cycle, on cycles with beat_valid high, into
// the first idle track and the best steal candidate (lowest priority not
// above the request, then oldest stamp, then lowest index).
// ----------------------------------------------------------------------------
module pva_select import pva_pkg::*; #(
   parameter int IDX_W      = 4,
   parameter int STAMP_BITS = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    clear,
   input  logic signed [PRI_W-1:0] clear_pri,
   input  logic                    beat_valid,
   input  logic [IDX_W-1:0]        beat_idx,
   input  logic                    beat_busy,
   input  logic signed [PRI_W-1:0] beat_pri,
   input  logic [STAMP_BITS-1:0]   beat_stamp,
   output pick_type                pick,
   output logic [IDX_W-1:0]        idle_idx,
   output logic [IDX_W-1:0]        best_idx
);

   logic                    idle_found_ff, idle_found_in;
   logic                    best_found_ff, best_found_in;
   logic [IDX_W-1:0]        idle_idx_ff, idle_idx_in;
   logic [IDX_W-1:0]        best_idx_ff, best_idx_in;
   logic signed [PRI_W-1:0] best_pri_ff, best_pri_in;
   logic [STAMP_BITS-1:0]   best_stamp_ff, best_stamp_in;
   logic                    take_idle;
   logic                    take_best;

   // Compare this word against the running picks
   always_comb begin
      take_idle = beat_valid && !beat_busy && !idle_found_ff;
      take_best = beat_valid && beat_busy &&
                  ((beat_pri < best_pri_ff) ||
                   ((beat_pri == best_pri_ff) &&
                    (!best_found_ff || (beat_stamp < best_stamp_ff))));
   end

   // Advance the running picks, or restart them for a new request
   always_comb begin
      idle_found_in = idle_found_ff;
      idle_idx_in   = idle_idx_ff;
      best_found_in = best_found_ff;
      best_idx_in   = best_idx_ff;
      best_pri_in   = best_pri_ff;
      best_stamp_in = best_stamp_ff;
      if (clear) begin
         idle_found_in = 1'b0;
         best_found_in = 1'b0;
         best_pri_in   = clear_pri;
      end else begin
         if (take_idle) begin
            idle_found_in = 1'b1;
            idle_idx_in   = beat_idx;
         end
         if (take_best) begin
            best_found_in = 1'b1;
            best_idx_in   = beat_idx;
            best_pri_in   = beat_pri;
            best_stamp_in = beat_stamp;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idle_found_ff <= 1'b0;
         best_found_ff <= 1'b0;
      end else begin
         idle_found_ff <= idle_found_in;
         best_found_ff <= best_found_in;
      end
   end

   always_ff @(posedge clock) begin
      idle_idx_ff   <= idle_idx_in;
      best_idx_ff   <= best_idx_in;
      best_pri_ff   <= best_pri_in;
      best_stamp_ff <= best_stamp_in;
   end

   assign pick.idle_found  = idle_found_ff;
   assign pick.steal_found = best_found_ff;
   assign idle_idx         = idle_idx_ff;
   assign best_idx         = best_idx_ff;

endmodule

[hw/rtl/priority_voice_allocator_unit.sv]
// ----------------------------------------------------------------------------
// Priority voice allocator - top level
// Hands out playback tracks by priority, stealing the weakest busy track
// when none is idle and its priority is not above the request's.
//
//   channel   ports                                   handshake
//   request   req_command, req_priority_req,          start & !busy
//             req_release_track
//   result    rsp_granted, rsp_track, rsp_stolen      rsp_valid strobe
//
// A release keeps busy low, and its result strobes in the next cycle. A
// request keeps busy high through the scan (one memory read per track
// through the single read port, then a drain of the last word) and the
// commit, and its result strobes in the cycle after the commit.
// Reset clears the busy flags, the start counter and the sequencer.
// Results are not held off; each word shows for one cycle only.
// ----------------------------------------------------------------------------
module priority_voice_allocator_unit import pva_pkg::*; #(
   parameter int TRACKS     = 16,
   parameter int STAMP_BITS = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic                      req_command,
   input  logic signed [PRI_W-1:0]   req_priority_req,
   input  logic [TRACK_W-1:0]        req_release_track,
   output logic                      rsp_valid,
   output logic                      rsp_granted,
   output logic [TRACK_W-1:0]        rsp_track,
   output logic                      rsp_stolen
);

   localparam int IDX_W = $clog2(TRACKS);
   localparam int MEM_W = PRI_W + STAMP_BITS;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TRACKS - 1);

   state_type               state_ff, state_in;
   logic [TRACKS-1:0]       busy_ff, busy_in;
   logic [STAMP_BITS-1:0]   counter_ff, counter_in;
   logic signed [PRI_W-1:0] pri_ff, pri_in;
   logic                    issue_on_ff, issue_on_in;
   logic [IDX_W-1:0]        issue_idx_ff, issue_idx_in;
   logic                    rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0]        rd_idx_ff, rd_idx_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_granted_ff, rsp_granted_in;
   logic [TRACK_W-1:0]      rsp_track_ff, rsp_track_in;
   logic                    rsp_stolen_ff, rsp_stolen_in;

   logic                    accept;
   logic                    req_accept;
   logic                    wr_en;
   logic [IDX_W-1:0]        chosen_idx;
   logic                    grant;
   logic [MEM_W-1:0]        rd_data;
   pick_type                pick;
   logic [IDX_W-1:0]        idle_idx;
   logic [IDX_W-1:0]        best_idx;

   assign accept     = start && !busy;
   assign req_accept = accept && (req_command == CMD_REQUEST);
   assign busy       = (state_ff != ST_IDLE);

   // Pick the track: an idle one first, otherwise the steal candidate
   assign grant      = pick.idle_found || pick.steal_found;
   assign chosen_idx = pick.idle_found ? idle_idx : best_idx;
   assign wr_en      = (state_ff == ST_COMMIT) && grant;

   // Track memory: priority over start stamp. Reads happen only in the
   // scan and writes only in commit, so the ports never touch one entry
   // in the same cycle.
   pva_mem #(
      .DEPTH (TRACKS),
      .WIDTH (MEM_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (chosen_idx),
      .wr_data ({pri_ff, counter_ff}),
      .rd_en   (issue_on_ff),
      .rd_addr (issue_idx_ff),
      .rd_data (rd_data)
   );

   pva_select #(
      .IDX_W      (IDX_W),
      .STAMP_BITS (STAMP_BITS)
   ) u_select (
      .clock      (clock),
      .reset      (reset),
      .clear      (req_accept),
      .clear_pri  (req_priority_req),
      .beat_valid (rd_vld_ff),
      .beat_idx   (rd_idx_ff),
      .beat_busy  (busy_ff[rd_idx_ff]),
      .beat_pri   ($signed(rd_data[MEM_W-1 -: PRI_W])),
      .beat_stamp (rd_data[STAMP_BITS-1:0]),
      .pick       (pick),
      .idle_idx   (idle_idx),
      .best_idx   (best_idx)
   );

   // Sequence accepts, the scan and the commit
   always_comb begin
      state_in       = state_ff;
      busy_in        = busy_ff;
      counter_in     = counter_ff;
      pri_in         = pri_ff;
      issue_on_in    = issue_on_ff;
      issue_idx_in   = issue_idx_ff;
      rd_vld_in      = issue_on_ff;
      rd_idx_in      = issue_idx_ff;
      rsp_valid_in   = 1'b0;
      rsp_granted_in = 1'b0;
      rsp_track_in   = '0;
      rsp_stolen_in  = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_command == CMD_RELEASE) begin
                  // Drop the busy flag of an existing track, answer with zeros
                  if (32'(req_release_track) < TRACKS) begin
                     busy_in[IDX_W'(req_release_track)] = 1'b0;
                  end
                  rsp_valid_in = 1'b1;
               end else begin
                  pri_in       = req_priority_req;
                  issue_on_in  = 1'b1;
                  issue_idx_in = '0;
                  state_in     = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            // Issue one read per track; leave once the last word is folded
            if (issue_on_ff) begin
               if (issue_idx_ff == LAST_IDX) begin
                  issue_on_in = 1'b0;
               end else begin
                  issue_idx_in = issue_idx_ff + 1'b1;
               end
            end
            if (rd_vld_ff && (rd_idx_ff == LAST_IDX)) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            // Mark a granted track busy, stamp it, and answer in either case
            if (grant) begin
               busy_in[chosen_idx] = 1'b1;
               if (counter_ff != '1) begin
                  counter_in = counter_ff + 1'b1;
               end
               rsp_track_in = TRACK_W'(chosen_idx);
            end
            rsp_valid_in   = 1'b1;
            rsp_granted_in = grant;
            rsp_stolen_in  = !pick.idle_found && pick.steal_found;
            state_in       = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         busy_ff      <= '0;
         counter_ff   <= '0;
         issue_on_ff  <= 1'b0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         busy_ff      <= busy_in;
         counter_ff   <= counter_in;
         issue_on_ff  <= issue_on_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pri_ff         <= pri_in;
      issue_idx_ff   <= issue_idx_in;
      rd_idx_ff      <= rd_idx_in;
      rsp_granted_ff <= rsp_granted_in;
      rsp_track_ff   <= rsp_track_in;
      rsp_stolen_ff  <= rsp_stolen_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_granted = rsp_granted_ff;
   assign rsp_track   = rsp_track_ff;
   assign rsp_stolen  = rsp_stolen_ff;

endmodule

[hw/rtl/pva_checker.sv]
// ----------------------------------------------------------------------------
// Priority voice allocator - port checker
// Watches the top level's ports and flags results that break the contract.
// ----------------------------------------------------------------------------
`include "priority_voice_allocator_unit_macros.svh"

module pva_checker import pva_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic               req_command,
   input logic               rsp_valid,
   input logic               rsp_granted,
   input logic [TRACK_W-1:0] rsp_track,
   input logic               rsp_stolen
);

   logic take_request;
   logic take_release;
   logic rsp_empty;

   // Classify the input word taken at this edge
   assign take_request = start && !busy && (req_command == CMD_REQUEST);
   assign take_release = start && !busy && (req_command == CMD_RELEASE);
   assign rsp_empty    = (rsp_track == '0) && !rsp_stolen;

   // A refused word or a release answer carries no track and no steal
   `PVA_ASSERT_SAME(a_refuse_zero, clock, reset, rsp_valid && !rsp_granted, rsp_empty)

   // A release answers in the very next cycle
   `PVA_ASSERT_NEXT(a_release_answer, clock, reset, take_release, rsp_valid && !rsp_granted && !busy)

   // A request holds the block busy while the tracks are scanned
   `PVA_ASSERT_NEXT(a_request_busy, clock, reset, take_request, busy && !rsp_valid)

   // A result word is only shown once the block is free again
   `PVA_ASSERT_SAME(a_result_free, clock, reset, rsp_valid, !busy)

endmodule

bind priority_voice_allocator_unit pva_checker u_pva_checker (.*);

[tb/pva_grant_checker.sv]
// ----------------------------------------------------------------------------
// Priority voice allocator - grant checker
// Watches the request and result channels of the allocator. Keeps its own
// copy of the track table, predicts the result word of every accepted
// request or release, and compares each result word with the oldest
// prediction.
// ----------------------------------------------------------------------------
module pva_grant_checker import pva_pkg::*; #(
   parameter int TRACKS     = 16,
   parameter int STAMP_BITS = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic                    busy,
   input  logic                    req_command,
   input  logic signed [PRI_W-1:0] req_priority_req,
   input  logic [TRACK_W-1:0]      req_release_track,
   input  logic                    rsp_valid,
   input  logic                    rsp_granted,
   input  logic [TRACK_W-1:0]      rsp_track,
   input  logic                    rsp_stolen,
   output int                      grants_outstanding,
   output int                      fail_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic               granted;
      logic [TRACK_W-1:0] track;
      logic               stolen;
   } grant_word_type;

   // Shadow track table
   logic                    track_busy  [TRACKS];
   logic signed [PRI_W-1:0] track_pri   [TRACKS];
   logic [STAMP_BITS-1:0]   track_stamp [TRACKS];
   logic [STAMP_BITS-1:0]   stamp_counter;

   grant_word_type expected_grants [$];

   // Append one prediction behind the ones already waiting
   function automatic void queue_grant(input grant_word_type w);
      expected_grants = {expected_grants, w};
   endfunction

   // Apply one input word to the shadow table and return its result word
   function automatic grant_word_type allocate_voice(input logic cmd,
                                                     input logic signed [PRI_W-1:0] pri,
                                                     input logic [TRACK_W-1:0] rel);
      grant_word_type          word;
      int                      chosen;
      logic signed [PRI_W-1:0] best_pri;
      logic [STAMP_BITS-1:0]   best_stamp;
      logic                    steal;
      word       = '0;
      chosen     = -1;
      steal      = 1'b0;
      best_pri   = pri;
      best_stamp = '0;

      // Release: mark idle, keep priority and stamp
      if (cmd == CMD_RELEASE) begin
         if (rel < TRACKS)
            track_busy[rel] = 1'b0;
         return word;
      end

      // Take the lowest idle track first
      for (int i = 0; i < TRACKS; i++) begin
         if (chosen < 0 && !track_busy[i])
            chosen = i;
      end

      // All busy: weakest priority not above the request, oldest stamp on ties
      if (chosen < 0) begin
         for (int i = 0; i < TRACKS; i++) begin
            if (track_pri[i] < best_pri) begin
               chosen     = i;
               best_pri   = track_pri[i];
               best_stamp = track_stamp[i];
            end else if (track_pri[i] == best_pri &&
                         (chosen < 0 || track_stamp[i] < best_stamp)) begin
               chosen     = i;
               best_stamp = track_stamp[i];
            end
         end
         steal = (chosen >= 0);
      end

      // Refused: no state change
      if (chosen < 0)
         return word;

      track_busy[chosen]  = 1'b1;
      track_pri[chosen]   = pri;
      track_stamp[chosen] = stamp_counter;
      if (stamp_counter != '1)
         stamp_counter = stamp_counter + 1'b1;

      word.granted = 1'b1;
      word.track   = chosen[TRACK_W-1:0];
      word.stolen  = steal;
      return word;
   endfunction

   always @(posedge clock) begin : watch
      grant_word_type want;
      if (reset) begin
         for (int i = 0; i < TRACKS; i++) begin
            track_busy[i]  = 1'b0;
            track_pri[i]   = '0;
            track_stamp[i] = '0;
         end
         stamp_counter = '0;
         expected_grants.delete();
         fail_count = 0;
      end else begin
         // Compare a result word with the oldest prediction
         if (rsp_valid) begin
            if (expected_grants.size() == 0) begin
               $error("result word with no prediction waiting");
               fail_count++;
            end else begin
               want = expected_grants.pop_front();
               if (rsp_granted !== want.granted) begin
                  $error("granted: expected %0d, actual %0d", want.granted, rsp_granted);
                  fail_count++;
               end
               if (rsp_track !== want.track) begin
                  $error("track: expected %0d, actual %0d", want.track, rsp_track);
                  fail_count++;
               end
               if (rsp_stolen !== want.stolen) begin
                  $error("stolen: expected %0d, actual %0d", want.stolen, rsp_stolen);
                  fail_count++;
               end
            end
         end
         // Predict on every accepted input word
         if (start && !busy)
            queue_grant(allocate_voice(req_command, req_priority_req, req_release_track));
      end
      grants_outstanding = expected_grants.size();
   end

endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// Priority voice allocator - testbench top
// Drives a directed fill-and-steal sequence followed by phases of random
// requests and releases, with random sender gaps in phases that enable them,
// and reports the verdict from the grant checker's failure count.
// ----------------------------------------------------------------------------
module tb_top import pva_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STALL_LIMIT  = 4000;
   localparam int PHASES       = 10;
   localparam int PHASE_WORDS  = 113;

   logic                    clock;
   logic                    reset             = 1'b1;
   logic                    start             = 1'b0;
   logic                    busy;
   logic                    req_command       = CMD_REQUEST;
   logic signed [PRI_W-1:0] req_priority_req  = '0;
   logic [TRACK_W-1:0]      req_release_track = '0;
   logic                    rsp_valid;
   logic                    rsp_granted;
   logic [TRACK_W-1:0]      rsp_track;
   logic                    rsp_stolen;

   int grants_outstanding;
   int fail_count;
   int idle_edges;
   bit sender_gaps = 1'b0;

   // Priorities used to fill all sixteen tracks in the directed part
   logic signed [PRI_W-1:0] fill_pri [16] = '{8'sd127, -8'sd128, 8'sd5, 8'sd5,
                                             8'sd0, -8'sd1, 8'sd64, -8'sd64,
                                             8'sd1, 8'sd2, 8'sd3, 8'sd4,
                                             8'sd10, 8'sd20, 8'sd30, 8'sd40};

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   priority_voice_allocator_unit uut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_command       (req_command),
      .req_priority_req  (req_priority_req),
      .req_release_track (req_release_track),
      .rsp_valid         (rsp_valid),
      .rsp_granted       (rsp_granted),
      .rsp_track         (rsp_track),
      .rsp_stolen        (rsp_stolen)
   );

   pva_grant_checker grant_check (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_command        (req_command),
      .req_priority_req   (req_priority_req),
      .req_release_track  (req_release_track),
      .rsp_valid          (rsp_valid),
      .rsp_granted        (rsp_granted),
      .rsp_track          (rsp_track),
      .rsp_stolen         (rsp_stolen),
      .grants_outstanding (grants_outstanding),
      .fail_count         (fail_count)
   );

   // Drive one word from a falling edge; return on the falling edge after it is taken
   task automatic send_word(input logic cmd, input logic signed [PRI_W-1:0] pri,
                            input logic [TRACK_W-1:0] rel);
      int gap;
      gap = sender_gaps ? $urandom_range(0, 16) : 0;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start             <= 1'b1;
      req_command       <= cmd;
      req_priority_req  <= pri;
      req_release_track <= rel;
      do @(posedge clock); while (busy !== 1'b0);
      @(negedge clock);
   endtask

   // Hold off the sender until every predicted word has come back
   task automatic drain_grants();
      start <= 1'b0;
      @(negedge clock);
      while (grants_outstanding != 0) @(negedge clock);
   endtask

   // Stimulus
   initial begin
      int req_pct;
      bit narrow_pri;
      logic signed [PRI_W-1:0] pri;

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Release an idle track, then fill every track
      send_word(CMD_RELEASE, 8'sd0, 4'd3);
      for (int i = 0; i < 16; i++)
         send_word(CMD_REQUEST, fill_pri[i], 4'd0);
      // Steal the only lowest track, steal again, refuse, equal-priority steal
      send_word(CMD_REQUEST, -8'sd128, 4'd0);
      send_word(CMD_REQUEST, 8'sd5, 4'd0);
      send_word(CMD_REQUEST, -8'sd128, 4'd0);
      send_word(CMD_REQUEST, -8'sd64, 4'd0);
      // Free the edge tracks and grant them back
      send_word(CMD_RELEASE, 8'sd0, 4'd15);
      send_word(CMD_RELEASE, -8'sd1, 4'd0);
      send_word(CMD_REQUEST, 8'sd127, 4'd0);
      send_word(CMD_REQUEST, 8'sd127, 4'd15);
      drain_grants();

      // Random phases with their own request mix, priority spread and gaps
      for (int ph = 0; ph < PHASES; ph++) begin
         req_pct     = $urandom_range(25, 90);
         narrow_pri  = 1'($urandom_range(0, 1));
         sender_gaps = ($urandom_range(0, 3) != 0);
         for (int n = 0; n < PHASE_WORDS; n++) begin
            if (narrow_pri && $urandom_range(0, 9) < 7)
               pri = PRI_W'($urandom_range(0, 4) - 2);
            else
               pri = PRI_W'($urandom_range(0, 255));
            if ($urandom_range(0, 99) < req_pct)
               send_word(CMD_REQUEST, pri, TRACK_W'($urandom_range(0, 15)));
            else
               send_word(CMD_RELEASE, pri, TRACK_W'($urandom_range(0, 15)));
         end
         drain_grants();
      end

      repeat (24) @(posedge clock);
      if (fail_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   // Watchdog: count edges with no word taken on either channel
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_edges <= 0;
      end else begin
         idle_edges <= idle_edges + 1;
         if (idle_edges >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/pva_pkg.sv
hw/rtl/pva_mem.sv
hw/rtl/pva_select.sv
hw/rtl/priority_voice_allocator_unit.sv
hw/rtl/pva_checker.sv
tb/pva_grant_checker.sv
tb/tb_top.sv
